### design/icrb_pkg.sv
package icrb_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Transaction kinds on the mode input
  typedef enum logic [1:0] {
    MODE_READ       = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_HW_PEND    = 2'd2,
    MODE_SET_ACTIVE = 2'd3
  } mode_t;

  // Bit-array blocks, selected by word_address[7:5] inside 0x040-0x0DF
  typedef enum logic [2:0] {
    BLK_SET_EN   = 3'd2,
    BLK_CLR_EN   = 3'd3,
    BLK_SET_PEND = 3'd4,
    BLK_CLR_PEND = 3'd5,
    BLK_ACTIVE   = 3'd6
  } blk_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request fields
    logic execute;  // commit state update and load result registers
  } dp_cmd_t;

  localparam logic [15:0] CTRL_KEY      = 16'h05FA;
  localparam logic [15:0] CTRL_READ_TAG = 16'hFA05;
  localparam logic [9:0]  CTRL_WORD     = 10'h343;
  localparam logic [9:0]  SHP_BASE      = 10'h346;
  localparam int          SHP_WORDS     = 3;
  localparam logic [3:0]  IPR_PAGE      = 4'b0100;  // word_address[9:6] of 0x100-0x13F
  localparam logic [5:0]  IPR_WORDS     = 6'd60;

  // Mask of implemented lines within one 32-line bit word
  function automatic logic [31:0] row_mask(input int row, input int lines);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      if (row * 32 + b < lines) m[b] = 1'b1;
    end
    return m;
  endfunction

endpackage

### design/icrb_ctrl.sv
module icrb_ctrl
  import icrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: state_next = start ? ST_EXEC : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    done        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: cmd.capture = start;
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      ST_RESP: begin
        done        = 1'b1;
        cmd.capture = start;
      end
      default: ;
    endcase
  end

endmodule

### design/icrb_datapath.sv
module icrb_datapath
  import icrb_pkg::*;
#(
  parameter int NUM_IRQS      = 82,
  parameter int PRIORITY_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  mode,
  input  logic [9:0]  word_address,
  input  logic [31:0] write_data,
  input  logic [3:0]  byte_enable,
  input  logic [7:0]  irq_line,
  input  logic        active_value,
  output logic [31:0] read_data,
  output logic        bad_access,
  output logic        reset_request
);

  localparam int NBW = (NUM_IRQS + 31) / 32;   // 32-line bit words
  localparam int NPW = (NUM_IRQS + 3) / 4;     // 4-line priority words
  localparam int PSH = 8 - PRIORITY_BITS;      // unimplemented low priority bits
  localparam logic [7:0] NUM_IRQS_B = 8'(NUM_IRQS);

  // latched request
  mode_t       mode_q;
  logic [9:0]  addr_q;
  logic [31:0] wd_q;
  logic [3:0]  be_q;
  logic [7:0]  line_q;
  logic        av_q;

  // architectural state
  logic [31:0] en_q [NBW];
  logic [31:0] pend_q [NBW];
  logic [31:0] act_q [NBW];
  logic [3:0][PRIORITY_BITS-1:0] lp_q [NPW];
  logic [3:0][PRIORITY_BITS-1:0] hp_q [SHP_WORDS];
  logic [2:0] pg_q;

  logic [31:0] en_next [NBW];
  logic [31:0] pend_next [NBW];
  logic [31:0] act_next [NBW];
  logic [3:0][PRIORITY_BITS-1:0] lp_next [NPW];
  logic [3:0][PRIORITY_BITS-1:0] hp_next [SHP_WORDS];
  logic [2:0] pg_next;

  logic [31:0] rd;
  logic        bad;
  logic        rst_req;
  logic        wr;
  logic [4:0]  bw;
  logic [5:0]  pw;
  logic [1:0]  sw;
  logic [9:0]  shp_off;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode_t'(mode);
      addr_q <= word_address;
      wd_q   <= write_data;
      be_q   <= byte_enable;
      line_q <= irq_line;
      av_q   <= active_value;
    end
  end

  assign wr      = (mode_q == MODE_WRITE);
  assign bw      = addr_q[4:0];
  assign pw      = addr_q[5:0];
  assign shp_off = addr_q - SHP_BASE;
  assign sw      = shp_off[1:0];

  always_comb begin
    en_next   = en_q;
    pend_next = pend_q;
    act_next  = act_q;
    lp_next   = lp_q;
    hp_next   = hp_q;
    pg_next   = pg_q;
    rd        = '0;
    bad       = 1'b0;
    rst_req   = 1'b0;

    if (mode_q == MODE_HW_PEND || mode_q == MODE_SET_ACTIVE) begin
      // hardware event on one line
      if (line_q < NUM_IRQS_B) begin
        for (int k = 0; k < NBW; k++) begin
          if (line_q[7:5] == 3'(k)) begin
            if (mode_q == MODE_HW_PEND) pend_next[k][line_q[4:0]] = 1'b1;
            else act_next[k][line_q[4:0]] = av_q;
          end
        end
      end else begin
        bad = 1'b1;
      end
    end else if (addr_q[9:8] == 2'b00 && addr_q[7:5] >= BLK_SET_EN &&
                 addr_q[7:5] <= BLK_ACTIVE) begin
      // enable / pending / active bit words
      if (bw >= 5'(NBW)) begin
        bad = 1'b1;
      end else begin
        for (int k = 0; k < NBW; k++) begin
          if (bw == 5'(k)) begin
            unique case (addr_q[7:5])
              BLK_SET_EN, BLK_CLR_EN: begin
                if (!wr) rd = en_q[k];
                else if (addr_q[5]) en_next[k] = en_q[k] & ~(wd_q & row_mask(k, NUM_IRQS));
                else en_next[k] = en_q[k] | (wd_q & row_mask(k, NUM_IRQS));
              end
              BLK_SET_PEND, BLK_CLR_PEND: begin
                if (!wr) rd = pend_q[k];
                else if (addr_q[5]) pend_next[k] = pend_q[k] & ~(wd_q & row_mask(k, NUM_IRQS));
                else pend_next[k] = pend_q[k] | (wd_q & row_mask(k, NUM_IRQS));
              end
              BLK_ACTIVE: begin
                if (!wr) rd = act_q[k];
              end
              default: ;
            endcase
          end
        end
      end
    end else if (addr_q[9:6] == IPR_PAGE && pw < IPR_WORDS) begin
      // per-line priority bytes
      if (pw >= 6'(NPW)) begin
        bad = 1'b1;
      end else begin
        for (int k = 0; k < NPW; k++) begin
          if (pw == 6'(k)) begin
            for (int i = 0; i < 4; i++) begin
              if (k * 4 + i < NUM_IRQS) begin
                if (!wr) rd[8*i +: 8] = 8'(lp_q[k][i]) << PSH;
                else if (be_q[i]) lp_next[k][i] = wd_q[8*i+PSH +: PRIORITY_BITS];
              end
            end
          end
        end
      end
    end else if (addr_q >= SHP_BASE && addr_q < SHP_BASE + 10'(SHP_WORDS)) begin
      // system handler priority bytes
      for (int k = 0; k < SHP_WORDS; k++) begin
        if (sw == 2'(k)) begin
          for (int i = 0; i < 4; i++) begin
            if (!wr) rd[8*i +: 8] = 8'(hp_q[k][i]) << PSH;
            else if (be_q[i]) hp_next[k][i] = wd_q[8*i+PSH +: PRIORITY_BITS];
          end
        end
      end
    end else if (addr_q == CTRL_WORD) begin
      if (!wr) begin
        rd = {CTRL_READ_TAG, 5'b0, pg_q, 8'b0};
      end else if (wd_q[31:16] == CTRL_KEY) begin
        pg_next = wd_q[10:8];
        rst_req = wd_q[2];
      end
    end else begin
      bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NBW; k++) begin
        en_q[k]   <= '0;
        pend_q[k] <= '0;
        act_q[k]  <= '0;
      end
      for (int k = 0; k < NPW; k++) lp_q[k] <= '0;
      for (int k = 0; k < SHP_WORDS; k++) hp_q[k] <= '0;
      pg_q <= '0;
    end else if (cmd.execute) begin
      en_q   <= en_next;
      pend_q <= pend_next;
      act_q  <= act_next;
      lp_q   <= lp_next;
      hp_q   <= hp_next;
      pg_q   <= pg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_data     <= (mode_q == MODE_READ) ? rd : '0;
      bad_access    <= bad;
      reset_request <= rst_req;
    end
  end

endmodule

### design/interrupt_controller_register_bank_unit.sv
// Result: an accepted transaction goes through EXEC, which loads the result
// registers; the result is then on the result ports, with done high, in RESP.
// Throughput: start is ignored while busy is high in EXEC; it is taken again
// while done is high, so execute-then-respond in the controller sets the rate.
// Reset (rst, synchronous): all enable, pending, active and priority state and
// the priority group clear to zero. The receiver cannot stall a result.
module interrupt_controller_register_bank_unit
  import icrb_pkg::*;
#(
  parameter int NUM_IRQS      = 82,   // implemented interrupt lines, 1..240
  parameter int PRIORITY_BITS = 4     // implemented priority bits, 1..8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  mode,
  input  logic [9:0]  word_address,
  input  logic [31:0] write_data,
  input  logic [3:0]  byte_enable,
  input  logic [7:0]  irq_line,
  input  logic        active_value,
  output logic [31:0] read_data,
  output logic        bad_access,
  output logic        reset_request
);

  // Controller: IDLE -> EXEC -> RESP. A transaction is accepted in IDLE or
  // RESP (busy low); EXEC commits the register update and loads the result
  // registers; RESP shows the result for exactly one cycle.
  dp_cmd_t cmd;

  icrb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath: request latch, decode of the system control space, the bit
  // arrays (enable, pending, active), the priority byte stores and the
  // priority group, plus the result registers.
  icrb_datapath #(
    .NUM_IRQS      (NUM_IRQS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .word_address  (word_address),
    .write_data    (write_data),
    .byte_enable   (byte_enable),
    .irq_line      (irq_line),
    .active_value  (active_value),
    .read_data     (read_data),
    .bad_access    (bad_access),
    .reset_request (reset_request)
  );

endmodule

### design/icrb_checker.sv
module icrb_checker
  import icrb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  mode,
  input logic [31:0] write_data,
  input logic [31:0] read_data,
  input logic        bad_access,
  input logic        reset_request
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not enter execute");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("execute not followed by result");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted transaction");

  a_rst_req: assert property (@(posedge clk) disable iff (rst)
    (done && reset_request) |-> ($past(mode, 2) == MODE_WRITE &&
      $past(write_data[31:16], 2) == CTRL_KEY && !bad_access))
    else $error("reset request without keyed write");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (done && read_data != '0) |-> ($past(mode, 2) == MODE_READ && !bad_access))
    else $error("read data on non-read transaction");

endmodule

bind interrupt_controller_register_bank_unit icrb_checker u_icrb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .mode          (mode),
  .write_data    (write_data),
  .read_data     (read_data),
  .bad_access    (bad_access),
  .reset_request (reset_request)
);
